>>> rtl/pnp_pkg.sv
// pnp_pkg: shared constants, action codes and the edge result struct
// of the point-in-polygon block; used by every other file in rtl
`default_nettype none

package pnp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int COUNT_W          = 7;  // width of the vertex_count field
  localparam int EVAL_DEPTH       = 3;  // register stages in the edge unit

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_QUERY  = 2'd2
  } act_e;

  typedef struct packed {
    logic valid;
    logic toggle;
  } eval_res_t;

endpackage

`default_nettype wire

>>> rtl/pnp_if.sv
// pnp_if: valid/ready channel interfaces for the point-in-polygon block
// depends on pnp_pkg for default widths
`default_nettype none

interface pnp_in_if
  import pnp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;

  modport source (output valid, action, x_coord, y_coord, input ready);
  modport sink   (input valid, action, x_coord, y_coord, output ready);
endinterface

interface pnp_out_if
  import pnp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               inside_res;
  logic [COUNT_W-1:0] vertex_count;
  logic               append_dropped;

  modport source (output valid, inside_res, vertex_count, append_dropped, input ready);
  modport sink   (input valid, inside_res, vertex_count, append_dropped, output ready);
endinterface

`default_nettype wire

>>> rtl/pnp_cell.sv
// pnp_cell: one vertex slot of the rotating vertex ring
// loads a new vertex or takes its neighbor's vertex during a walk
`default_nettype none

module pnp_cell
  import pnp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         load_en,
  input  wire                         shift_en,
  input  wire signed [COORD_BITS-1:0] load_x,
  input  wire signed [COORD_BITS-1:0] load_y,
  input  wire signed [COORD_BITS-1:0] nbr_x,
  input  wire signed [COORD_BITS-1:0] nbr_y,
  output logic signed [COORD_BITS-1:0] x_r,
  output logic signed [COORD_BITS-1:0] y_r
);

  always_ff @(posedge clk) begin
    if (load_en) begin
      x_r <= load_x;
      y_r <= load_y;
    end else if (shift_en) begin
      x_r <= nbr_x;
      y_r <= nbr_y;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pnp_edge_eval.sv
// pnp_edge_eval: three-stage crossing test for one polygon edge per cycle
// differences, then exact cross products, then the signed compare
`default_nettype none

module pnp_edge_eval
  import pnp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         issue,
  input  wire signed [COORD_BITS-1:0] xi,
  input  wire signed [COORD_BITS-1:0] yi,
  input  wire signed [COORD_BITS-1:0] xj,
  input  wire signed [COORD_BITS-1:0] yj,
  input  wire signed [COORD_BITS-1:0] px,
  input  wire signed [COORD_BITS-1:0] py,
  output eval_res_t                   res_r
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] xi_e, yi_e, xj_e, yj_e, px_e, py_e;
  logic signed [DW-1:0] dy_nxt, lhs_nxt, rhs_a_nxt, rhs_b_nxt;
  logic                 straddle_nxt;

  logic                 s1_valid_r, s1_straddle_r;
  logic signed [DW-1:0] s1_dy_r, s1_lhs_r, s1_rhs_a_r, s1_rhs_b_r;

  logic                 s2_valid_r, s2_straddle_r, s2_dy_pos_r;
  logic signed [PW-1:0] s2_p1_r, s2_p2_r;
  logic signed [PW-1:0] p1_nxt, p2_nxt;
  logic                 left_nxt;

  assign xi_e = {xi[COORD_BITS-1], xi};
  assign yi_e = {yi[COORD_BITS-1], yi};
  assign xj_e = {xj[COORD_BITS-1], xj};
  assign yj_e = {yj[COORD_BITS-1], yj};
  assign px_e = {px[COORD_BITS-1], px};
  assign py_e = {py[COORD_BITS-1], py};

  assign straddle_nxt = (yi > py) != (yj > py);
  assign dy_nxt       = yj_e - yi_e;
  assign lhs_nxt      = px_e - xi_e;
  assign rhs_a_nxt    = xj_e - xi_e;
  assign rhs_b_nxt    = py_e - yi_e;

  assign p1_nxt = PW'(s1_lhs_r) * PW'(s1_dy_r);
  assign p2_nxt = PW'(s1_rhs_a_r) * PW'(s1_rhs_b_r);

  // dy is nonzero whenever the edge straddles, so its sign picks the order
  assign left_nxt = s2_dy_pos_r ? (s2_p1_r < s2_p2_r) : (s2_p2_r < s2_p1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      res_r      <= '0;
    end else begin
      s1_valid_r   <= issue;
      s2_valid_r   <= s1_valid_r;
      res_r.valid  <= s2_valid_r;
      res_r.toggle <= s2_valid_r && s2_straddle_r && left_nxt;
    end
    s1_straddle_r <= straddle_nxt;
    s1_dy_r       <= dy_nxt;
    s1_lhs_r      <= lhs_nxt;
    s1_rhs_a_r    <= rhs_a_nxt;
    s1_rhs_b_r    <= rhs_b_nxt;
    s2_straddle_r <= s1_straddle_r;
    s2_dy_pos_r   <= !s1_dy_r[DW-1];
    s2_p1_r       <= p1_nxt;
    s2_p2_r       <= p2_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/point_in_polygon_test.sv
// point_in_polygon_test: polygon vertex store with even-odd point queries
// depends on pnp_pkg, pnp_if, pnp_cell and pnp_edge_eval
//
// usage
//   in_ch carries one action per transfer: append a vertex, clear the store,
//   or query the point (x_coord, y_coord). every action gives exactly one
//   transfer on out_ch with inside_res, the vertex count after the action and
//   append_dropped (append to a full store of MAX_VERTICES vertices).
//   vertices sit in a ring of MAX_VERTICES cells. a query rotates the ring one
//   full turn, one cell per cycle, feeding each stored edge to a three-stage
//   crossing unit; the turn is full whatever the number of stored vertices,
//   and the unit is drained before the final step. append, clear and unused
//   codes skip the walk and go straight to the final step.
//   one action is in flight at a time: in_ch.ready is high only while idle,
//   so a new action waits until the block is back in idle. the result
//   sits in an output register; a stalled receiver holds the block in its
//   final step until the transfer.
//   reset (rst_n low, synchronous) empties the store and drops any result in
//   flight; cell contents are not cleared.
`default_nettype none

module point_in_polygon_test
  import pnp_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  pnp_in_if.sink     in_ch,
  pnp_out_if.source  out_ch
);

  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int STEP_W  = $clog2(MAX_VERTICES);
  localparam int DRAIN_W = $clog2(EVAL_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     stored_count_r;
  logic [STEP_W-1:0]    step_r;
  logic [DRAIN_W-1:0]   drain_r;
  logic                 parity_r;
  logic                 dropped_pend_r;

  logic signed [COORD_BITS-1:0] last_x_r, last_y_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic signed [COORD_BITS-1:0] pt_x_r, pt_y_r;

  logic                 out_valid_r, out_inside_r, out_dropped_r;
  logic [CNT_W-1:0]     out_count_r;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  logic                 accept, do_append, full, walking, issue, out_free;
  eval_res_t            ev_res;

  logic signed [COORD_BITS-1:0] cell_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] cell_y [MAX_VERTICES];

  assign accept    = in_ch.valid && in_ch.ready;
  assign full      = stored_count_r == CNT_W'(MAX_VERTICES);
  assign do_append = accept && (in_ch.action == ACT_APPEND) && !full;
  assign walking   = state_r == ST_WALK;
  assign issue     = walking && (CNT_W'(step_r) < stored_count_r);
  assign out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready = state_r == ST_IDLE;

  // ring of vertex cells, rotating toward cell 0 during a query
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    pnp_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .load_en  (do_append && (stored_count_r == CNT_W'(k))),
      .shift_en (walking),
      .load_x   (in_ch.x_coord),
      .load_y   (in_ch.y_coord),
      .nbr_x    (cell_x[(k + 1) % MAX_VERTICES]),
      .nbr_y    (cell_y[(k + 1) % MAX_VERTICES]),
      .x_r      (cell_x[k]),
      .y_r      (cell_y[k])
    );
  end

  pnp_edge_eval #(
    .COORD_BITS (COORD_BITS)
  ) u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .xi    (cell_x[0]),
    .yi    (cell_y[0]),
    .xj    (prev_x_r),
    .yj    (prev_y_r),
    .px    (pt_x_r),
    .py    (pt_y_r),
    .res_r (ev_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      stored_count_r <= '0;
      out_valid_r    <= 1'b0;
      step_r         <= '0;
      drain_r        <= '0;
      parity_r       <= 1'b0;
      dropped_pend_r <= 1'b0;
    end else begin
      // in the final step a new result replaces the one leaving
      if (out_valid_r && out_ch.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (ev_res.valid && ev_res.toggle) begin
        parity_r <= !parity_r;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            parity_r       <= 1'b0;
            dropped_pend_r <= 1'b0;
            step_r         <= '0;
            unique case (in_ch.action)
              ACT_APPEND: begin
                state_r <= ST_DONE;
                if (full) begin
                  dropped_pend_r <= 1'b1;
                end else begin
                  stored_count_r <= stored_count_r + CNT_W'(1);
                end
              end
              ACT_CLEAR: begin
                state_r        <= ST_DONE;
                stored_count_r <= '0;
              end
              ACT_QUERY: begin
                state_r <= ST_WALK;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (step_r == STEP_W'(MAX_VERTICES - 1)) begin
            step_r  <= '0;
            drain_r <= DRAIN_W'(EVAL_DEPTH - 1);
            state_r <= ST_DRAIN;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_DRAIN: begin
          drain_r <= drain_r - DRAIN_W'(1);
          if (drain_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (do_append) begin
      last_x_r <= in_ch.x_coord;
      last_y_r <= in_ch.y_coord;
    end
    if (accept) begin
      pt_x_r   <= in_ch.x_coord;
      pt_y_r   <= in_ch.y_coord;
      // the closing edge pairs vertex 0 with the last stored vertex
      prev_x_r <= last_x_r;
      prev_y_r <= last_y_r;
    end else if (issue) begin
      prev_x_r <= cell_x[0];
      prev_y_r <= cell_y[0];
    end
    if (state_r == ST_DONE && out_free) begin
      out_inside_r  <= parity_r;
      out_dropped_r <= dropped_pend_r;
      out_count_r   <= stored_count_r;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, out_count_r};

  assign out_ch.valid          = out_valid_r;
  assign out_ch.inside_res     = out_inside_r;
  assign out_ch.vertex_count   = count_ext[COUNT_W-1:0];
  assign out_ch.append_dropped = out_dropped_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above store depth");

  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && $past(state_r) == ST_WALK) |-> step_r == '0)
    else $error("ring did not complete a full turn");

  a_edge_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    ev_res.valid |-> (state_r == ST_WALK || state_r == ST_DRAIN))
    else $error("edge result outside a query");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.append_dropped) |-> out_count_r == CNT_W'(MAX_VERTICES))
    else $error("dropped append with room in the store");

  a_no_toggle_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (stored_count_r == '0) |-> !issue)
    else $error("edge issued for an empty polygon");
`endif

endmodule

`default_nettype wire

>>> test/tb_point_in_polygon_test.sv
// tb_point_in_polygon_test: self-checking bench for the point-in-polygon block,
// with a queue-fed driver, a result monitor and an even-odd crossing predictor
// depends on rtl/pnp_pkg.sv, rtl/pnp_if.sv and rtl/point_in_polygon_test.sv
module tb_point_in_polygon_test;
  import pnp_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int MAX_V       = MAX_VERTICES_DEF;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 400;
  localparam int TARGET      = 1050;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]            action;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
  } action_item_t;

  typedef struct packed {
    logic               in_poly;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } poly_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pnp_in_if #(.COORD_BITS(CW)) in_ch ();
  pnp_out_if out_ch ();

  action_item_t drv_item = '0;
  logic drv_valid = 1'b0;
  logic sink_ready = 1'b0;

  assign in_ch.valid   = drv_valid;
  assign in_ch.action  = drv_item.action;
  assign in_ch.x_coord = drv_item.x;
  assign in_ch.y_coord = drv_item.y;
  assign out_ch.ready  = sink_ready;

  point_in_polygon_test #(.MAX_VERTICES(MAX_V), .COORD_BITS(CW)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial forever #6 clk = ~clk;

  // stimulus and expectations
  action_item_t pending_actions[$];
  poly_result_t expected_results[$];

  // predictor copy of the vertex store
  logic signed [CW-1:0] poly_x[MAX_V];
  logic signed [CW-1:0] poly_y[MAX_V];
  int poly_count = 0;

  int n_items = 0;
  int accept_count = 0;
  int errors = 0;
  int cycles = 0;
  int n_queries = 0;
  int n_inside = 0;
  int n_dropped = 0;
  int n_results = 0;

  logic quiet;
  logic hold_on = 1'b0;
  assign quiet = (n_items > 0) && (accept_count >= n_items - 150);

  // stimulus-side copy of the current polygon, for aiming query points
  logic signed [CW-1:0] shape_x[$];
  logic signed [CW-1:0] shape_y[$];

  task automatic flag_error(input string msg);
    if (errors < 40) $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // even-odd parity of ray crossings; cross-multiplied so no division is needed
  function automatic logic ray_parity(input logic signed [CW-1:0] px,
                                      input logic signed [CW-1:0] py);
    longint xi, yi, xj, yj, dy, lhs, rhs;
    logic odd;
    int j;
    odd = 1'b0;
    if (poly_count == 0) return 1'b0;
    j = poly_count - 1;
    for (int i = 0; i < poly_count; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if ((yi > longint'(py)) != (yj > longint'(py))) begin
        dy  = yj - yi;
        lhs = (longint'(px) - xi) * dy;
        rhs = (xj - xi) * (longint'(py) - yi);
        if ((dy > 0) ? (lhs < rhs) : (rhs < lhs)) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic poly_result_t predict_action(input logic [1:0] act,
                                                  input logic signed [CW-1:0] x,
                                                  input logic signed [CW-1:0] y);
    poly_result_t r;
    r = '0;
    case (act)
      ACT_APPEND: begin
        if (poly_count < MAX_V) begin
          poly_x[poly_count] = x;
          poly_y[poly_count] = y;
          poly_count++;
        end else begin
          r.dropped = 1'b1;
          n_dropped++;
        end
      end
      ACT_CLEAR: poly_count = 0;
      ACT_QUERY: begin
        r.in_poly = ray_parity(x, y);
        n_queries++;
        if (r.in_poly) n_inside++;
      end
      default: ;
    endcase
    r.count = poly_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic push_action(input logic [1:0] act, input int x, input int y);
    action_item_t it;
    it.action = act;
    it.x = x[CW-1:0];
    it.y = y[CW-1:0];
    pending_actions = {pending_actions, it};
    if (act == ACT_CLEAR) begin
      shape_x.delete();
      shape_y.delete();
    end else if (act == ACT_APPEND) begin
      shape_x = {shape_x, it.x};
      shape_y = {shape_y, it.y};
    end
  endtask

  // spread 0: whole range, negative: extremes and values around zero only, else +/- spread
  function automatic int pick_coord(input int spread);
    int corner[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    if (spread == 0) return int'($signed(16'($urandom)));
    if (spread < 0) return corner[$urandom_range(0, 6)];
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  task automatic push_query(input int spread);
    int k;
    k = shape_x.size() > 0 ? $urandom_range(0, shape_x.size() - 1) : 0;
    if (shape_x.size() == 0 || $urandom_range(0, 9) == 0) begin
      push_action(ACT_QUERY, pick_coord(spread), pick_coord(spread));
    end else begin
      case ($urandom_range(0, 4))
        0: push_action(ACT_QUERY, shape_x[k], shape_y[k]);
        1: push_action(ACT_QUERY, pick_coord(spread), shape_y[k]);
        2: push_action(ACT_QUERY, int'(shape_x[k]) + $urandom_range(0, 2) - 1,
                       pick_coord(spread));
        default: push_action(ACT_QUERY, pick_coord(spread), pick_coord(spread));
      endcase
    end
  endtask

  task automatic push_polygon(input int n_vert, input int spread, input bit fresh);
    int n_q;
    if (fresh) push_action(ACT_CLEAR, pick_coord(0), pick_coord(0));
    repeat (n_vert) push_action(ACT_APPEND, pick_coord(spread), pick_coord(spread));
    n_q = $urandom_range(1, 6);
    repeat (n_q) push_query(spread);
  endtask

  task automatic build_stimulus();
    int spreads[4] = '{24, 2000, 0, -1};
    // directed: empty store, unused code, degenerate shapes, full-range square
    push_action(ACT_QUERY, 0, 0);
    push_action(ACT_UNUSED, 32767, -32768);
    push_action(ACT_CLEAR, -1, -1);
    push_action(ACT_APPEND, 0, 0);
    push_action(ACT_QUERY, 0, 0);
    push_action(ACT_APPEND, 0, 0);
    push_action(ACT_QUERY, -1, 0);
    push_action(ACT_CLEAR, 0, 0);
    push_action(ACT_APPEND, -32768, -32768);
    push_action(ACT_APPEND, 32767, -32768);
    push_action(ACT_APPEND, 32767, 32767);
    push_action(ACT_APPEND, -32768, 32767);
    push_action(ACT_QUERY, 0, 0);
    push_action(ACT_QUERY, -32768, 0);
    push_action(ACT_QUERY, 32767, 0);
    push_action(ACT_QUERY, -32768, -32768);
    push_action(ACT_QUERY, 32767, 32767);
    push_action(ACT_QUERY, 0, 32767);
    push_action(ACT_UNUSED, -1, -1);
    push_action(ACT_APPEND, 0, 0);
    push_action(ACT_QUERY, -32767, -32767);
    push_action(ACT_CLEAR, 0, 0);
    // fill the store past its end so appends get dropped
    push_polygon(MAX_V + 2, 2000, 1'b1);
    while (pending_actions.size() < TARGET) begin
      if ($urandom_range(0, 99) < 6) begin
        case ($urandom_range(0, 2))
          0: push_action(ACT_UNUSED, pick_coord(0), pick_coord(0));
          1: push_action(ACT_APPEND, pick_coord(0), pick_coord(0));
          default: push_action(ACT_QUERY, pick_coord(0), pick_coord(0));
        endcase
      end else if ($urandom_range(0, 19) == 0) begin
        push_polygon($urandom_range(MAX_V - 4, MAX_V + 4), spreads[$urandom_range(0, 3)],
                     $urandom_range(0, 4) != 0);
      end else begin
        push_polygon($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(3, 12),
                     spreads[$urandom_range(0, 3)], $urandom_range(0, 4) != 0);
      end
    end
  endtask

  // driver: offers the head of the queue, with random gaps after transfers
  int seen_count = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (accept_count != seen_count) begin
        seen_count = accept_count;
        if (!quiet && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        drv_valid <= 1'b0;
        gap_left--;
      end else if (pending_actions.size() > 0) begin
        drv_valid <= 1'b1;
        drv_item <= pending_actions[0];
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // receiver: short random stalls, plus one long hold-off
  int stall_left = 0;
  always @(negedge clk) begin
    if (!rst_n || hold_on) begin
      sink_ready <= 1'b0;
    end else if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  initial begin
    wait (accept_count >= 200);
    @(negedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on <= 1'b0;
  end

  // input transfer: update the predictor and queue what should come back
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_results = {expected_results,
                          predict_action(in_ch.action, in_ch.x_coord, in_ch.y_coord)};
      void'(pending_actions.pop_front());
      accept_count <= accept_count + 1;
    end
  end

  // result transfer: compare with the oldest expectation
  always @(posedge clk) begin
    poly_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        flag_error("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_ch.inside_res !== want.in_poly)
          flag_error($sformatf("inside_res got %b want %b", out_ch.inside_res, want.in_poly));
        if (out_ch.vertex_count !== want.count)
          flag_error($sformatf("vertex_count got %0d want %0d",
                               out_ch.vertex_count, want.count));
        if (out_ch.append_dropped !== want.dropped)
          flag_error($sformatf("append_dropped got %b want %b",
                               out_ch.append_dropped, want.dropped));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    n_items = pending_actions.size();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (accept_count < n_items || expected_results.size() > 0) @(posedge clk);
    repeat (MAX_V + 16) @(posedge clk);
    $display("ran %0d actions, %0d results: %0d queries (%0d inside), %0d dropped appends",
             n_items, n_results, n_queries, n_inside, n_dropped);
    $display("%0d field mismatches", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pnp_pkg.sv
rtl/pnp_if.sv
rtl/pnp_cell.sv
rtl/pnp_edge_eval.sv
rtl/point_in_polygon_test.sv
test/tb_point_in_polygon_test.sv
